>>> hw/rtl/v3n_pkg.sv
// v3n_pkg: shared types for the vector normalizer pipeline.
// No dependencies.
package v3n_pkg;
  // sideband carried alongside the datapath stages
  typedef struct packed {
    logic       valid;
    logic [2:0] neg;
  } v3n_ctl_t;
endpackage

>>> hw/rtl/vector3_normalizer.sv
// vector3_normalizer: top level, a chain of square-root cells then divider cells.
// Depends on v3n_pkg, v3n_sqrt_cell, v3n_div_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries comp_x/y/z (signed). Result
//   channel out_valid/out_ready carries unit_x/y/z (signed Q1.FRACTION_BITS),
//   magnitude (floor sqrt of sum of squares) and zero_length.
//   A front stage takes magnitudes and squares (one multiplier per component),
//   a sum stage adds them, then COMPONENT_BITS+1 root cells each settle one
//   root bit, then COMPONENT_BITS+FRACTION_BITS divider cells each settle
//   one quotient bit for all three components. A final stage applies signs.
//   Throughput: one transaction per cycle unless stalled; the whole chain advances together.
//   When the receiver stalls with a result pending, the chain freezes and
//   in_ready drops; the output register holds its transaction unchanged.
//   Reset clears all valid bits; no clearing pass is needed.
//   A zero vector yields zero units, magnitude 0 and zero_length set.
module vector3_normalizer #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COMPONENT_BITS-1:0] in_comp_x,
  input  logic signed [COMPONENT_BITS-1:0] in_comp_y,
  input  logic signed [COMPONENT_BITS-1:0] in_comp_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [FRACTION_BITS+1:0] out_unit_x,
  output logic signed [FRACTION_BITS+1:0] out_unit_y,
  output logic signed [FRACTION_BITS+1:0] out_unit_z,
  output logic [COMPONENT_BITS-1:0]       out_magnitude,
  output logic                            out_zero_length
);
  localparam int MW = COMPONENT_BITS;      // component magnitude width
  localparam int SW = 2 * MW + 2;          // sum of three squares
  localparam int RW = MW + 1;              // root width
  localparam int NW = MW + FRACTION_BITS;  // dividend width
  localparam int UW = FRACTION_BITS + 2;   // unit width
  localparam int NS = RW;                  // root cells
  localparam int ND = NW;                  // divider cells

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: magnitudes and squares
  v3n_pkg::v3n_ctl_t c0_r;
  logic [MW-1:0]   m0_r [3];
  logic [2*MW-1:0] q0_r [3];
  logic [MW-1:0]   mag_in [3];
  logic [MW-1:0]   raw [3];
  assign raw[0] = in_comp_x;
  assign raw[1] = in_comp_y;
  assign raw[2] = in_comp_z;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // two's-complement negate; most negative stays at its full magnitude
      mag_in[i] = raw[i][MW-1] ? MW'(~raw[i] + MW'(1)) : raw[i];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (en) begin
      c0_r.valid <= in_valid;
      c0_r.neg   <= {raw[2][MW-1], raw[1][MW-1], raw[0][MW-1]};
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m0_r[i] <= mag_in[i];
        q0_r[i] <= (2*MW)'(mag_in[i]) * (2*MW)'(mag_in[i]);
      end
    end
  end

  // stage 1: sum of squares
  v3n_pkg::v3n_ctl_t c1_r;
  logic [SW-1:0]     s1_r;
  logic [3*MW-1:0]   m1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= c0_r;
    end
    if (en) begin
      s1_r <= SW'(q0_r[0]) + SW'(q0_r[1]) + SW'(q0_r[2]);
      m1_r <= {m0_r[2], m0_r[1], m0_r[0]};
    end
  end

  // square-root chain
  v3n_pkg::v3n_ctl_t sc [NS+1];
  logic [SW-1:0]     sr [NS+1];
  logic [RW-1:0]     so [NS+1];
  logic [3*MW-1:0]   sm [NS+1];
  assign sc[0] = c1_r;
  assign sr[0] = s1_r;
  assign so[0] = '0;
  assign sm[0] = m1_r;
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    v3n_sqrt_cell #(.SW(SW), .RW(RW), .MW(MW), .STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(sc[k]), .rem_i(sr[k]), .root_i(so[k]), .mag_i(sm[k]),
      .ctl_o(sc[k+1]), .rem_o(sr[k+1]), .root_o(so[k+1]), .mag_o(sm[k+1])
    );
  end

  // divider chain: numerator = magnitude << FRACTION_BITS
  v3n_pkg::v3n_ctl_t dc [ND+1];
  logic [RW-1:0]     dd [ND+1];
  logic [3*NW-1:0]   dn [ND+1];
  logic [3*RW-1:0]   dr [ND+1];
  logic [3*NW-1:0]   dq [ND+1];
  assign dc[0] = sc[NS];
  assign dd[0] = so[NS];
  assign dr[0] = '0;
  assign dq[0] = '0;
  for (genvar i = 0; i < 3; i++) begin : g_num
    assign dn[0][i*NW +: NW] = {sm[NS][i*MW +: MW], {FRACTION_BITS{1'b0}}};
  end
  for (genvar k = 0; k < ND; k++) begin : g_div
    v3n_div_cell #(.NW(NW), .DW(RW), .QW(NW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(dc[k]), .den_i(dd[k]), .num_i(dn[k]), .rem_i(dr[k]), .quo_i(dq[k]),
      .ctl_o(dc[k+1]), .den_o(dd[k+1]), .num_o(dn[k+1]), .rem_o(dr[k+1]),
      .quo_o(dq[k+1])
    );
  end

  // output register: sign and zero handling
  logic          zero;
  logic [UW-1:0] q [3];
  assign zero = (dd[ND] == '0);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = dq[ND][i*NW +: UW];
      if (zero) begin
        q[i] = '0;
      end else if (dc[ND].neg[i]) begin
        q[i] = UW'(~q[i] + UW'(1));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dc[ND].valid;
    end
    if (en) begin
      out_unit_x      <= q[0];
      out_unit_y      <= q[1];
      out_unit_z      <= q[2];
      out_magnitude   <= dd[ND][MW-1:0];
      out_zero_length <= zero;
    end
  end
endmodule

>>> hw/rtl/v3n_sqrt_cell.sv
// v3n_sqrt_cell: one restoring square-root step, registered.
// Depends on v3n_pkg.
module v3n_sqrt_cell #(
  parameter int SW = 34,
  parameter int RW = 17,
  parameter int MW = 16,
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  v3n_pkg::v3n_ctl_t  ctl_i,
  input  logic [SW-1:0]      rem_i,
  input  logic [RW-1:0]      root_i,
  input  logic [3*MW-1:0]    mag_i,
  output v3n_pkg::v3n_ctl_t  ctl_o,
  output logic [SW-1:0]      rem_o,
  output logic [RW-1:0]      root_o,
  output logic [3*MW-1:0]    mag_o
);
  localparam int B = RW - 1 - STEP;
  logic [SW-1:0] trial;
  logic [SW-1:0] root_sh;
  logic          take;
  v3n_pkg::v3n_ctl_t ctl_r;
  logic [SW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [3*MW-1:0] mag_r;

  // trial = (root << (B+1)) | (1 << 2B), root holds bits above B
  always_comb begin
    root_sh = SW'(root_i) << (B + 1);
    trial   = root_sh | (SW'(1) << (2 * B));
    take    = rem_i >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      rem_r  <= take ? rem_i - trial : rem_i;
      root_r <= take ? (root_i | (RW'(1) << B)) : root_i;
      mag_r  <= mag_i;
    end
  end
  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign mag_o  = mag_r;
endmodule

>>> hw/rtl/v3n_div_cell.sv
// v3n_div_cell: one restoring division step for three quotients in parallel.
// Depends on v3n_pkg.
module v3n_div_cell #(
  parameter int NW = 31,
  parameter int DW = 17,
  parameter int QW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  v3n_pkg::v3n_ctl_t  ctl_i,
  input  logic [DW-1:0]      den_i,
  input  logic [3*NW-1:0]    num_i,
  input  logic [3*DW-1:0]    rem_i,
  input  logic [3*QW-1:0]    quo_i,
  output v3n_pkg::v3n_ctl_t  ctl_o,
  output logic [DW-1:0]      den_o,
  output logic [3*NW-1:0]    num_o,
  output logic [3*DW-1:0]    rem_o,
  output logic [3*QW-1:0]    quo_o
);
  v3n_pkg::v3n_ctl_t ctl_r;
  logic [DW-1:0]   den_r;
  logic [3*NW-1:0] num_r;
  logic [3*DW-1:0] rem_nxt, rem_r;
  logic [3*QW-1:0] quo_nxt, quo_r;
  logic [DW:0]     sh [3];

  // numerator bits enter MSB first; shift left each step
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {rem_i[i*DW +: DW], num_i[i*NW + NW - 1]};
      if (sh[i] >= {1'b0, den_i}) begin
        rem_nxt[i*DW +: DW] = DW'(sh[i] - {1'b0, den_i});
        quo_nxt[i*QW +: QW] = {quo_i[i*QW +: QW-1], 1'b1};
      end else begin
        rem_nxt[i*DW +: DW] = sh[i][DW-1:0];
        quo_nxt[i*QW +: QW] = {quo_i[i*QW +: QW-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      den_r <= den_i;
      for (int i = 0; i < 3; i++) begin
        num_r[i*NW +: NW] <= num_i[i*NW +: NW] << 1;
      end
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end
  assign ctl_o = ctl_r;
  assign den_o = den_r;
  assign num_o = num_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
endmodule

>>> hw/rtl/v3n_checker.sv
// v3n_checker: port-level assertions for vector3_normalizer, bound below.
// Depends on vector3_normalizer ports only.
module v3n_checker #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 14
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [FRACTION_BITS+1:0]   out_unit_x,
  input logic [COMPONENT_BITS-1:0]  out_magnitude,
  input logic                       out_zero_length
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |-> out_magnitude == '0 && out_unit_x == '0)
    else $error("zero flag with nonzero result");
  a_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_length |-> out_magnitude != '0)
    else $error("zero length without flag");
endmodule

bind vector3_normalizer v3n_checker #(
  .COMPONENT_BITS(COMPONENT_BITS), .FRACTION_BITS(FRACTION_BITS)
) u_v3n_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_unit_x(out_unit_x), .out_magnitude(out_magnitude),
  .out_zero_length(out_zero_length)
);

>>> tb/vector3_normalizer_tb.sv
// vector3_normalizer_tb: self-checking testbench for the vector normalizer.
// Depends on vector3_normalizer (and v3n_pkg through it); predicts each result in place.
`timescale 1ns / 1ps

module vector3_normalizer_tb;

  localparam int CB = 16;
  localparam int FB = 14;
  localparam int LATENCY = 2 * CB + FB + 4;

  typedef struct packed {
    logic signed [FB+1:0] ux;
    logic signed [FB+1:0] uy;
    logic signed [FB+1:0] uz;
    logic [CB-1:0]        mag;
    logic                 zl;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] in_comp_x = '0;
  logic signed [CB-1:0] in_comp_y = '0;
  logic signed [CB-1:0] in_comp_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FB+1:0] out_unit_x, out_unit_y, out_unit_z;
  logic [CB-1:0] out_magnitude;
  logic out_zero_length;

  unit_vec_t expected_units[$];
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  // receiver mode: 0 random stalls, 1 always ready, 2 long hold-off
  int rx_mode = 0;
  int rx_seen = 0;
  int rx_wait = 0;

  vector3_normalizer #(.COMPONENT_BITS(CB), .FRACTION_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_magnitude(out_magnitude), .out_zero_length(out_zero_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(sqrt(x)), bit-by-bit
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic unit_vec_t normalize(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                          logic signed [CB-1:0] z);
    longint unsigned m[3];
    logic neg[3];
    logic signed [CB-1:0] c[3];
    longint unsigned sum, len, q;
    logic [FB+1:0] u[3];
    unit_vec_t r;
    c[0] = x; c[1] = y; c[2] = z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i][CB-1];
      // full magnitude, most negative value included
      m[i] = neg[i] ? longint'(-longint'(c[i])) : longint'(c[i]);
      sum += m[i] * m[i];
    end
    len = floor_root(sum);
    r = '0;
    if (len == 0) begin
      r.zl = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FB) / len;
      u[i] = neg[i] ? (FB+2)'(0 - q) : (FB+2)'(q);
    end
    r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
    r.mag = len[CB-1:0];
    return r;
  endfunction

  // one transaction on the input channel, random gap first; valid stays up
  // between back-to-back transactions
  task automatic send_vector(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                             logic signed [CB-1:0] z, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 10) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_comp_x <= x; in_comp_y <= y; in_comp_z <= z;
    expected_units.push_back(normalize(x, y, z));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // receiver: ready pattern per mode; in random mode a new random wait
  // is drawn for every result taken
  always @(negedge clk) begin
    if (received != rx_seen) begin
      rx_seen = received;
      rx_wait = $urandom_range(0, 10);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_mode == 1) begin
      out_ready <= 1'b1;
    end else if (rx_mode == 2) begin
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    unit_vec_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_unit_x, out_unit_y, out_unit_z, out_magnitude, out_zero_length};
      received++;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = expected_units.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p got %p", received, want, got);
        end
      end
    end
  end

  task automatic test_directed();
    logic signed [CB-1:0] mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    send_vector(0, 0, 0);          // zero vector
    send_vector(mx, mx, mx);
    send_vector(mn, mn, mn);       // most negative everywhere, largest length
    send_vector(mn, 0, 0);
    send_vector(0, mn, 0);
    send_vector(0, 0, mn);
    send_vector(mx, 0, 0);
    send_vector(0, mx, 0);
    send_vector(0, 0, mx);
    send_vector(1, 0, 0);
    send_vector(CB'(-1), 0, 0);
    send_vector(0, CB'(-1), 0);
    send_vector(0, 0, 1);
    send_vector(1, 1, 1);
    send_vector(CB'(-1), CB'(-1), CB'(-1));
    send_vector(mn, mx, 0);
    send_vector(mx, mn, mn);
    send_vector(3, 4, 0);
    send_vector(CB'(-3), 0, 4);
    send_vector(0, 0, 0);
  endtask

  task automatic test_random(int n);
    logic signed [CB-1:0] v[3];
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(0, 5))
          0: v[i] = $signed(CB'($urandom_range(0, 7)) - CB'(4));   // tiny
          1: v[i] = ($urandom_range(0, 1)) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
          2: v[i] = '0;
          default: v[i] = CB'($urandom());
        endcase
      end
      send_vector(v[0], v[1], v[2]);
    end
  endtask

  // back-to-back input with the receiver always ready
  task automatic test_full_rate();
    rx_mode = 1;
    for (int k = 0; k < 150; k++)
      send_vector(CB'($urandom()), CB'($urandom()), CB'($urandom()), 1);
    rx_mode = 0;
  endtask

  // receiver holds off long enough that the pipe fills and in_ready drops
  task automatic test_backpressure();
    fork
      begin
        rx_mode = 2;
        repeat (LATENCY * 3) @(negedge clk);
        rx_mode = 0;
      end
      for (int k = 0; k < 120; k++)
        send_vector(CB'($urandom()), CB'($urandom()), CB'($urandom()), 1);
    join
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random(860);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_units.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("vector3_normalizer_tb: clean");
    end else begin
      $display("vector3_normalizer_tb: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("vector3_normalizer_tb: errors");
    $finish;
  end

endmodule
